// ===== rtl/failed_login_lockout_table_assert.svh =====
// assertion macros for the lockout table
`ifndef FAILED_LOGIN_LOCKOUT_TABLE_ASSERT_SVH
`define FAILED_LOGIN_LOCKOUT_TABLE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FLT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lockout table assertion failed");

// antecedent implies consequent in the next cycle
`define FLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lockout table assertion failed");

`endif

// ===== rtl/flt_pkg.sv =====
package flt_pkg;

    localparam int TABLE_ENTRIES = 16;

    localparam logic [1:0] FUNC_CHECK = 2'd0;
    localparam logic [1:0] FUNC_FAIL  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic CFG_MAX_ATTEMPTS  = 1'b0;
    localparam logic CFG_BLOCK_SECONDS = 1'b1;

    localparam logic [7:0]  COUNT_MAX = 8'hFF;
    localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    // request travelling along the row of entries
    typedef struct packed {
        logic        vld;
        logic [1:0]  func;
        logic [31:0] addr;
        logic [31:0] now;
        logic        found;
        logic        blocked;
        logic [7:0]  count;
        logic        free_seen;
    } tok_t;

    // end-of-scan broadcast to every entry
    typedef struct packed {
        logic done;
        logic commit;
    } ctl_t;

    function automatic logic [31:0] sat_end(input logic [31:0] now, input logic [15:0] secs);
        logic [32:0] sum;
        sum = {1'b0, now} + {17'd0, secs};
        return sum[32] ? TOTAL_MAX : sum[31:0];
    endfunction

endpackage

// ===== rtl/flt_cell.sv =====
module flt_cell
    import flt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  max_attempts,
    input  logic [15:0] block_seconds,
    input  ctl_t        ctl,
    input  tok_t        tok_in,
    output tok_t        tok_out
);

    logic        valid_reg, valid_next;
    logic        pend_reg, pend_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  count_reg, count_next;
    logic [31:0] end_reg, end_next;
    tok_t        tok_reg, tok_next;

    logic        match;
    logic        take_free;
    logic [7:0]  inc;

    always_comb begin
        match      = tok_in.vld && valid_reg && (addr_reg == tok_in.addr);
        take_free  = tok_in.vld && !valid_reg && (tok_in.func == FUNC_FAIL) && !tok_in.free_seen;
        inc        = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 8'd1;
        valid_next = valid_reg;
        pend_next  = pend_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        end_next   = end_reg;
        tok_next   = tok_in;

        if (match) begin
            tok_next.found = 1'b1;
            tok_next.count = count_reg;
            case (tok_in.func)
                FUNC_CHECK: begin
                    if (count_reg >= max_attempts) begin
                        if (tok_in.now < end_reg) begin
                            tok_next.blocked = 1'b1;
                        end else begin
                            count_next     = 8'd0;
                            end_next       = 32'd0;
                            tok_next.count = 8'd0;
                        end
                    end
                end
                FUNC_FAIL: begin
                    count_next     = inc;
                    tok_next.count = inc;
                    if (inc >= max_attempts) begin
                        end_next = sat_end(tok_in.now, block_seconds);
                    end
                end
                FUNC_CLEAR: begin
                    valid_next     = 1'b0;
                    tok_next.count = 8'd0;
                end
                default: begin
                    tok_next.count = count_reg;
                end
            endcase
        end

        // free slot: write a fresh entry now, make it live only on commit
        if (take_free) begin
            pend_next          = 1'b1;
            addr_next          = tok_in.addr;
            count_next         = 8'd1;
            end_next           = (8'd1 >= max_attempts) ? sat_end(tok_in.now, block_seconds)
                                                        : 32'd0;
            tok_next.free_seen = 1'b1;
        end

        if (ctl.done) begin
            pend_next = 1'b0;
            if (ctl.commit && pend_reg) begin
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg  <= addr_next;
        count_reg <= count_next;
        end_reg   <= end_next;
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/flt_ctrl.sv =====
module flt_ctrl
    import flt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output tok_t        tok_first,
    input  tok_t        tok_last,
    output ctl_t        ctl
);

    state_t      state_reg, state_next;
    tok_t        res_reg, res_next;
    logic [31:0] total_reg, total_next;
    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;

    logic        out_free;
    logic        is_fail;
    logic        full;
    logic [7:0]  count_out;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        tok_first           = '0;
        tok_first.vld       = s_tvalid && s_tready;
        tok_first.func      = s_tdata[1:0];
        tok_first.addr      = s_tdata[33:2];
        tok_first.now       = s_tdata[65:34];

        is_fail   = (res_reg.func == FUNC_FAIL);
        full      = is_fail && !res_reg.found && !res_reg.free_seen;
        count_out = res_reg.found ? res_reg.count
                  : ((is_fail && res_reg.free_seen) ? 8'd1 : 8'd0);

        state_next   = state_reg;
        res_next     = res_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        ctl          = '0;
        s_tready     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tok_last.vld) begin
                    res_next   = tok_last;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    ctl.done   = 1'b1;
                    ctl.commit = is_fail && !res_reg.found && res_reg.free_seen;
                    if (is_fail && !full && (total_reg != TOTAL_MAX)) begin
                        total_next = total_reg + 32'd1;
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, total_next, full, count_out, res_reg.blocked};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/failed_login_lockout_table.sv =====
// a request is taken in the idle state, walks the row of entry cells one cell per
// cycle, is captured at end of scan, then committed and sent out once the result
// register is free; a new request is accepted only after the previous one has
// been sent to the result register
// reset: synchronous active-low aresetn empties the table, zeroes the failure
// total and loads max_attempts 5 and block_seconds 300; no clearing pass
`include "failed_login_lockout_table_assert.svh"

module failed_login_lockout_table
    import flt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // func[1:0], client_addr[33:2], now_sec[65:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // blocked[0], attempt_count[8:1], table_full[9],
                                   // total_failures[41:10]
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [15:0] cfg_wdata
);

    logic [7:0]  max_attempts_reg;
    logic [15:0] block_seconds_reg;
    tok_t        tok [TABLE_ENTRIES+1];
    ctl_t        ctl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_attempts_reg  <= 8'd5;
            block_seconds_reg <= 16'd300;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_MAX_ATTEMPTS:  max_attempts_reg  <= cfg_wdata[7:0];
                CFG_BLOCK_SECONDS: block_seconds_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    flt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .tok_first (tok[0]),
        .tok_last  (tok[TABLE_ENTRIES]),
        .ctl       (ctl)
    );

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        flt_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .max_attempts  (max_attempts_reg),
            .block_seconds (block_seconds_reg),
            .ctl           (ctl),
            .tok_in        (tok[i]),
            .tok_out       (tok[i+1])
        );
    end

    `FLT_ASSERT_NEXT(a_busy_after_transfer, s_tvalid && s_tready, !s_tready)
    `FLT_ASSERT_SAME(a_full_has_no_count, m_tvalid && m_tdata[9], m_tdata[8:1] == 8'd0)
    `FLT_ASSERT_SAME(a_commit_at_done, ctl.commit, ctl.done)
    `FLT_ASSERT_SAME(a_full_not_blocked, m_tvalid && m_tdata[9], !m_tdata[0])

endmodule

// ===== verif/lockout_table_monitor.sv =====
`timescale 1ns / 1ps

module lockout_table_monitor
    import flt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // func[1:0], client_addr[33:2], now_sec[65:34]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // blocked[0], attempt_count[8:1], table_full[9],
                                   // total_failures[41:10]
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [15:0] cfg_wdata,
    output int          mismatch_count,
    output int          results_outstanding
);

    typedef struct packed {
        logic        blocked;
        logic [7:0]  attempts;
        logic        full;
        logic [31:0] total;
    } lockout_reply_t;

    logic [7:0]     limit_attempts;
    logic [15:0]    block_len;
    logic           slot_valid [TABLE_ENTRIES];
    logic [31:0]    slot_addr  [TABLE_ENTRIES];
    logic [7:0]     slot_count [TABLE_ENTRIES];
    logic [31:0]    slot_end   [TABLE_ENTRIES];
    logic [31:0]    fail_total;
    lockout_reply_t awaited_replies [$];

    function automatic lockout_reply_t apply_request(input logic [1:0] func,
                                                     input logic [31:0] addr,
                                                     input logic [31:0] now);
        lockout_reply_t r;
        int             hit;
        int             spare;
        int             i;
        logic [32:0]    end_sum;
        r = '0;
        hit = -1;
        spare = -1;
        // walk downwards so the lowest free slot wins
        for (i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (slot_valid[i] && slot_addr[i] == addr)
                hit = i;
            if (!slot_valid[i])
                spare = i;
        end
        case (func)
            FUNC_CHECK: begin
                if (hit >= 0) begin
                    if (slot_count[hit] >= limit_attempts) begin
                        if (now < slot_end[hit]) begin
                            r.blocked = 1'b1;
                        end else begin
                            slot_count[hit] = '0;
                            slot_end[hit]   = '0;
                        end
                    end
                    r.attempts = slot_count[hit];
                end
            end
            FUNC_FAIL: begin
                if (hit < 0 && spare >= 0) begin
                    hit = spare;
                    slot_valid[hit] = 1'b1;
                    slot_addr[hit]  = addr;
                    slot_count[hit] = '0;
                    slot_end[hit]   = '0;
                end
                if (hit < 0) begin
                    r.full = 1'b1;
                end else begin
                    if (slot_count[hit] != COUNT_MAX)
                        slot_count[hit] = slot_count[hit] + 8'd1;
                    if (fail_total != TOTAL_MAX)
                        fail_total = fail_total + 32'd1;
                    if (slot_count[hit] >= limit_attempts) begin
                        end_sum = {1'b0, now} + {17'd0, block_len};
                        slot_end[hit] = end_sum[32] ? TOTAL_MAX : end_sum[31:0];
                    end
                    r.attempts = slot_count[hit];
                end
            end
            FUNC_CLEAR: begin
                if (hit >= 0)
                    slot_valid[hit] = 1'b0;
            end
            default: begin
                if (hit >= 0)
                    r.attempts = slot_count[hit];
            end
        endcase
        r.total = fail_total;
        return r;
    endfunction

    always @(posedge aclk) begin : track
        lockout_reply_t got;
        lockout_reply_t want;
        int             i;
        if (!aresetn) begin
            limit_attempts = 8'd5;
            block_len      = 16'd300;
            fail_total     = '0;
            for (i = 0; i < TABLE_ENTRIES; i++)
                slot_valid[i] = 1'b0;
            awaited_replies.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_MAX_ATTEMPTS)
                    limit_attempts = cfg_wdata[7:0];
                else
                    block_len = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                awaited_replies.push_back(apply_request(s_tdata[1:0], s_tdata[33:2],
                                                        s_tdata[65:34]));
            if (m_tvalid && m_tready) begin
                got.blocked  = m_tdata[0];
                got.attempts = m_tdata[8:1];
                got.full     = m_tdata[9];
                got.total    = m_tdata[41:10];
                if (awaited_replies.size() == 0) begin
                    $error("result transfer with nothing outstanding: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.blocked !== want.blocked) begin
                        $error("blocked: expected %0d, got %0d", want.blocked, got.blocked);
                        mismatch_count++;
                    end
                    if (got.attempts !== want.attempts) begin
                        $error("attempt_count: expected %0d, got %0d",
                               want.attempts, got.attempts);
                        mismatch_count++;
                    end
                    if (got.full !== want.full) begin
                        $error("table_full: expected %0d, got %0d", want.full, got.full);
                        mismatch_count++;
                    end
                    if (got.total !== want.total) begin
                        $error("total_failures: expected %0d, got %0d", want.total, got.total);
                        mismatch_count++;
                    end
                end
            end
        end
        results_outstanding = awaited_replies.size();
    end

endmodule

// ===== verif/failed_login_lockout_table_test.sv =====
`timescale 1ns / 1ps

module failed_login_lockout_table_test;
    import flt_pkg::*;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int POOL_SIZE     = 24;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = TABLE_ENTRIES + 4;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // func[1:0], client_addr[33:2], now_sec[65:34]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // blocked[0], attempt_count[8:1], table_full[9],
                            // total_failures[41:10]
    logic        cfg_we;
    logic        cfg_idx;
    logic [15:0] cfg_wdata;

    int          mismatch_count;
    int          results_outstanding;
    int          idle_cycles;
    bit          quiet_stretch;
    bit          hold_request;
    logic [31:0] addr_pool [POOL_SIZE];
    logic [31:0] clock_sec;
    logic [15:0] cur_block;

    failed_login_lockout_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    lockout_table_monitor table_watch (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .cfg_we              (cfg_we),
        .cfg_idx             (cfg_idx),
        .cfg_wdata           (cfg_wdata),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("** failed_login_lockout_table: FAILED **");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= quiet_stretch || ($urandom_range(99) >= 6);
            end
        end
    end

    task automatic offer_request(input logic [1:0] func, input logic [31:0] addr,
                                 input logic [31:0] now);
        int gap;
        bit taken;
        gap = 0;
        repeat (TABLE_ENTRIES + 2) begin
            if (!quiet_stretch && $urandom_range(99) < 6)
                gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, now, addr, func};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic offer_random();
        int          pick;
        logic [1:0]  func;
        logic [31:0] addr;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 10) begin
            func = 2'($urandom_range(3));
            addr = $urandom;
            offer_request(func, addr, $urandom);
        end else begin
            if ($urandom_range(99) < 15)
                clock_sec = clock_sec + $urandom_range(2 * int'(cur_block));
            else
                clock_sec = clock_sec + $urandom_range(3);
            if (pick < 50)
                func = FUNC_FAIL;
            else if (pick < 85)
                func = FUNC_CHECK;
            else if (pick < 95)
                func = FUNC_CLEAR;
            else
                func = FUNC_SPARE;
            addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
            offer_request(func, addr, clock_sec);
        end
    endtask

    task automatic write_setting(input logic idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge aclk);
        while (results_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int          i;
        logic [31:0] hammer_addr;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_MAX_ATTEMPTS;
        cfg_wdata     = '0;
        quiet_stretch = 1'b0;
        hold_request  = 1'b0;
        addr_pool[0]  = 32'h0000_0000;
        addr_pool[1]  = 32'hFFFF_FFFF;
        for (i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;
        hammer_addr = 32'h5A5A_0001;
        cur_block   = 16'd300;
        clock_sec   = $urandom;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: overflowing block end, full table, expiry, clear
        repeat (5) offer_request(FUNC_FAIL, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        offer_request(FUNC_FAIL, addr_pool[0], 32'h0000_0000);
        for (i = 2; i < TABLE_ENTRIES; i++)
            offer_request(FUNC_FAIL, addr_pool[i], 32'h0000_0100);
        offer_request(FUNC_FAIL, 32'h8000_0001, 32'h0000_0200);
        offer_request(FUNC_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        offer_request(FUNC_SPARE, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_request(FUNC_CLEAR, 32'h8000_0001, 32'h0000_0000);
        offer_request(FUNC_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_request(FUNC_CLEAR, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_request(FUNC_CHECK, 32'hFFFF_FFFF, 32'h0000_0000);
        drain_results();

        // shortest block
        cur_block = 16'd1;
        write_setting(CFG_MAX_ATTEMPTS, {8'($urandom), 8'd2});
        write_setting(CFG_BLOCK_SECONDS, cur_block);
        repeat (120) offer_random();
        drain_results();

        // limit of zero, longest block
        cur_block = 16'hFFFF;
        write_setting(CFG_MAX_ATTEMPTS, {8'($urandom), 8'd0});
        write_setting(CFG_BLOCK_SECONDS, cur_block);
        repeat (80) offer_random();
        drain_results();

        // highest limit, one address hammered past count saturation
        cur_block = 16'($urandom_range(1, 65535));
        write_setting(CFG_MAX_ATTEMPTS, {8'($urandom), 8'd255});
        write_setting(CFG_BLOCK_SECONDS, cur_block);
        for (i = 0; i < 290; i++) begin
            if (i % 12 != 11)
                offer_request(FUNC_FAIL, hammer_addr, clock_sec);
            else
                offer_random();
        end
        offer_request(FUNC_CHECK, hammer_addr, clock_sec);
        drain_results();

        // ordinary settings with a long result hold-off and a stall-free stretch
        cur_block = 16'($urandom_range(1, 1000));
        write_setting(CFG_MAX_ATTEMPTS, 16'($urandom_range(1, 8)));
        write_setting(CFG_BLOCK_SECONDS, cur_block);
        hold_request = 1'b1;
        for (i = 0; i < 150; i++) begin
            quiet_stretch = (i >= 50 && i < 130);
            offer_random();
        end
        quiet_stretch = 1'b0;
        drain_results();

        if (mismatch_count == 0)
            $display("** failed_login_lockout_table: PASSED **");
        else
            $display("** failed_login_lockout_table: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/flt_pkg.sv
rtl/flt_cell.sv
rtl/flt_ctrl.sv
rtl/failed_login_lockout_table.sv
verif/lockout_table_monitor.sv
verif/failed_login_lockout_table_test.sv
